// File: hdl/gst_pkg.sv
// ----------------------------------------------------------------------------
// gst_pkg
// shared types and constants of the grandmaster stability tracker
// ----------------------------------------------------------------------------
`default_nettype none

package gst_pkg;

   localparam int TIME_W = 64;
   localparam int ID_W   = 64;
   localparam int MS_W   = 20;
   localparam int WAIT_W = 40;
   localparam int PASS_W = 4;

   localparam logic [MS_W-1:0]   NS_PER_MS     = 20'd1000000;
   localparam logic [WAIT_W-1:0] WAIT_RESET_NS = 40'd10000000000;
   localparam logic [PASS_W-1:0] LAST_PASS     = 4'd15;

   typedef enum logic [0:0] {
      CSR_INITIAL_STABLE = 1'b0,
      CSR_NORMAL_STABLE  = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      OP_EVALUATE = 1'b0,
      OP_REPORT   = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      TRK_INIT       = 3'd0,
      TRK_INITIALIZE = 3'd1,
      TRK_LOST       = 3'd2,
      TRK_UNSTABLE   = 3'd3,
      TRK_STABLE     = 3'd4
   } gm_state_type;

   typedef enum logic [1:0] {
      CTL_IDLE   = 2'd0,
      CTL_EVAL   = 2'd1,
      CTL_RESULT = 2'd2
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic pass;
   } dp_cmd_type;

   typedef struct packed {
      logic eval_go;
      logic settled;
   } dp_status_type;

endpackage

`default_nettype wire

// File: hdl/gst_ctrl.sv
// ----------------------------------------------------------------------------
// gst_ctrl
// sequencer: accepts an item, runs state passes (if due) until settled or the pass limit, holds result
// ----------------------------------------------------------------------------
`default_nettype none

module gst_ctrl
   import gst_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd,
   output logic               req_ready,
   output logic               rsp_valid
);

   ctl_state_type     state_ff, state_in;
   logic [PASS_W-1:0] pass_ff, pass_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE: begin
            if (req_valid) begin
               state_in = status.eval_go ? CTL_EVAL : CTL_RESULT;
            end
         end
         CTL_EVAL: begin
            if (status.settled || (pass_ff == LAST_PASS)) begin
               state_in = CTL_RESULT;
            end
         end
         CTL_RESULT: begin
            if (rsp_ready) begin
               state_in = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      pass_in = '0;
      if (state_ff == CTL_EVAL) begin
         pass_in = pass_ff + PASS_W'(1);
      end
   end

   always_comb begin
      cmd.load  = (state_ff == CTL_IDLE) && req_valid;
      cmd.pass  = (state_ff == CTL_EVAL);
      req_ready = (state_ff == CTL_IDLE);
      rsp_valid = (state_ff == CTL_RESULT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
         pass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/gst_dp.sv
// ----------------------------------------------------------------------------
// gst_dp
// tracker state, wait registers and the per-pass transition logic
// ----------------------------------------------------------------------------
`default_nettype none

module gst_dp
   import gst_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [MS_W-1:0]   csr_wdata,
   input  wire dp_cmd_type        cmd,
   input  wire logic              req_op,
   input  wire logic [TIME_W-1:0] req_now_ns,
   input  wire logic [ID_W-1:0]   req_gm_identity,
   input  wire logic              req_begin_req,
   input  wire logic              req_as_capable,
   input  wire logic              req_gm_sync,
   input  wire logic              req_port_is_slave,
   output dp_status_type          status,
   output logic                   is_stable,
   output logic                   init_done,
   output logic                   reset_sync,
   output gm_state_type           fsm_state
);

   logic [WAIT_W-1:0] init_wait_ff, init_wait_in;
   logic [WAIT_W-1:0] norm_wait_ff, norm_wait_in;

   logic [TIME_W-1:0] now_ff, now_in;
   logic              capable_ff, capable_in;
   logic              sync_ff, sync_in;
   logic              slave_ff, slave_in;

   gm_state_type      cur_ff, cur_in;
   gm_state_type      prev_ff, prev_in;
   logic [TIME_W-1:0] deadline_ff, deadline_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   logic [ID_W-1:0]   known_ff, known_in;
   logic              mark_ff, mark_in;
   logic              stable_ff, stable_in;
   logic              done_ff, done_in;
   logic              pulse_ff, pulse_in;

   logic              eval_go;
   logic              entered;
   logic              eff_sync;
   logic [TIME_W-1:0] deadline_new;
   logic [TIME_W-1:0] deadline_cmp;

   // wait periods kept in nanoseconds
   always_comb begin
      init_wait_in = init_wait_ff;
      norm_wait_in = norm_wait_ff;
      if (csr_we) begin
         if (csr_index == CSR_INITIAL_STABLE) begin
            init_wait_in = WAIT_W'(csr_wdata) * WAIT_W'(NS_PER_MS);
         end else begin
            norm_wait_in = WAIT_W'(csr_wdata) * WAIT_W'(NS_PER_MS);
         end
      end
   end

   assign eval_go      = (req_op == OP_EVALUATE) || (req_gm_identity != known_ff);
   assign entered      = (prev_ff != cur_ff);
   assign deadline_new = now_ff + TIME_W'(wait_ff);
   assign deadline_cmp = entered ? deadline_new : deadline_ff;

   always_comb begin
      now_in      = now_ff;
      capable_in  = capable_ff;
      sync_in     = sync_ff;
      slave_in    = slave_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      deadline_in = deadline_ff;
      wait_in     = wait_ff;
      known_in    = known_ff;
      mark_in     = mark_ff;
      stable_in   = stable_ff;
      done_in     = done_ff;
      pulse_in    = pulse_ff;
      eff_sync    = sync_ff && !pulse_ff;

      priority if (cmd.load) begin
         now_in     = req_now_ns;
         capable_in = req_as_capable;
         sync_in    = req_gm_sync;
         slave_in   = req_port_is_slave;
         pulse_in   = 1'b0;
         if (eval_go) begin
            if (req_op == OP_REPORT) begin
               known_in = req_gm_identity;
               mark_in  = 1'b1;
            end
            if (req_begin_req || !req_as_capable) begin
               cur_in = TRK_INITIALIZE;
            end
         end
      end else if (cmd.pass) begin
         prev_in = cur_ff;
         unique case (cur_ff)
            TRK_INIT: begin
               cur_in = TRK_INITIALIZE;
            end
            TRK_INITIALIZE: begin
               if (entered) begin
                  deadline_in = '0;
                  wait_in     = init_wait_ff;
                  done_in     = 1'b0;
                  stable_in   = 1'b0;
                  if (!slave_ff) begin
                     pulse_in = 1'b1;
                     eff_sync = 1'b0;
                  end
               end
               if (capable_ff && eff_sync) begin
                  cur_in = TRK_UNSTABLE;
               end
            end
            TRK_LOST: begin
               if (entered) begin
                  deadline_in = '0;
                  mark_in     = 1'b0;
               end
               if (eff_sync) begin
                  cur_in = TRK_UNSTABLE;
               end
            end
            TRK_UNSTABLE: begin
               if (entered) begin
                  deadline_in = deadline_new;
                  stable_in   = 1'b0;
               end
               if (now_ff > deadline_cmp) begin
                  cur_in = TRK_STABLE;
               end else if (mark_ff) begin
                  cur_in = TRK_LOST;
               end
            end
            default: begin
               if (entered) begin
                  deadline_in = '0;
                  wait_in     = norm_wait_ff;
                  stable_in   = 1'b1;
                  done_in     = 1'b1;
               end
               if (mark_ff) begin
                  cur_in = TRK_LOST;
               end
            end
         endcase
      end else begin
         eff_sync = sync_ff && !pulse_ff;
      end
   end

   always_comb begin
      status.eval_go = eval_go;
      status.settled = (cur_in == cur_ff);
   end

   assign is_stable  = stable_ff;
   assign init_done  = done_ff;
   assign reset_sync = pulse_ff;
   assign fsm_state  = cur_ff;

   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      capable_ff <= capable_in;
      sync_ff    <= sync_in;
      slave_ff   <= slave_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_wait_ff <= WAIT_RESET_NS;
         norm_wait_ff <= WAIT_RESET_NS;
         cur_ff       <= TRK_INIT;
         prev_ff      <= TRK_INIT;
         deadline_ff  <= '0;
         wait_ff      <= '0;
         known_ff     <= '0;
         mark_ff      <= 1'b0;
         stable_ff    <= 1'b0;
         done_ff      <= 1'b0;
         pulse_ff     <= 1'b0;
      end else begin
         init_wait_ff <= init_wait_in;
         norm_wait_ff <= norm_wait_in;
         cur_ff       <= cur_in;
         prev_ff      <= prev_in;
         deadline_ff  <= deadline_in;
         wait_ff      <= wait_in;
         known_ff     <= known_in;
         mark_ff      <= mark_in;
         stable_ff    <= stable_in;
         done_ff      <= done_in;
         pulse_ff     <= pulse_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/grandmaster_stability_tracker_unit.sv
// ----------------------------------------------------------------------------
// grandmaster_stability_tracker_unit
// Tracks grandmaster stability of one time-sync domain. Each req item is an
// evaluate tick (tuser 0) or a grandmaster identity report (tuser 1) with
// the current time in ns and the status flags; each item yields exactly one
// rsp item with the stable and init-done flags, the sync reset pulse and the
// tracker state. The two stability waits are set in ms over the csr port
// (index 0 initial, index 1 normal) and take effect at the next entry into
// the initialize or stable state.
// The item is taken, then state passes run until the state settles or the
// pass counter reaches LAST_PASS, and the result is held in its register;
// a report that repeats the stored identity skips the passes.
// One item is in work at a time; req_tready is low from acceptance until
// the result is taken, so a stalled receiver holds the block and the result.
// Reset (synchronous) returns the tracker to its init state, clears all
// flags and the stored identity, and sets both waits to 10000 ms.
// ----------------------------------------------------------------------------
`default_nettype none

module grandmaster_stability_tracker_unit
   import gst_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            csr_we,
   input  wire logic            csr_index,
   input  wire logic [MS_W-1:0] csr_wdata,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   // now_ns[63:0], gm_identity[127:64], begin_req[128], as_capable[129],
   // gm_sync[130], port_is_slave[131], zero fill[135:132]
   input  wire logic [135:0]    req_tdata,
   // op[0]
   input  wire logic [0:0]      req_tuser,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   // stable flag[0], init_done[1], reset_sync[2], fsm_state[5:3], zero fill[7:6]
   output logic [7:0]           rsp_tdata
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          is_stable;
   logic          init_done;
   logic          reset_sync;
   gm_state_type  fsm_state;

   gst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .rsp_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd),
      .req_ready (req_tready),
      .rsp_valid (rsp_tvalid)
   );

   gst_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .cmd               (cmd),
      .req_op            (req_tuser[0]),
      .req_now_ns        (req_tdata[63:0]),
      .req_gm_identity   (req_tdata[127:64]),
      .req_begin_req     (req_tdata[128]),
      .req_as_capable    (req_tdata[129]),
      .req_gm_sync       (req_tdata[130]),
      .req_port_is_slave (req_tdata[131]),
      .status            (status),
      .is_stable         (is_stable),
      .init_done         (init_done),
      .reset_sync        (reset_sync),
      .fsm_state         (fsm_state)
   );

   assign rsp_tdata = {2'b00, 3'(fsm_state), reset_sync, init_done, is_stable};

endmodule

`default_nettype wire
